FILE: hw/rtl/segx_pkg.sv
// Package for the segment intersection block: payload types, widths and constants.
// No dependencies.
`timescale 1ns / 1ps
package segx_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int DEN_BITS = PROD_BITS + 1;
  localparam int MAG_BITS = DEN_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } segx_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } segx_out_t;

  // Data carried from the setup stages into the divider.
  typedef struct packed {
    logic                  hit;
    logic                  neg_x;
    logic                  neg_y;
    logic [MAG_BITS-1:0]   den_mag;
    logic [COORD_BITS-1:0] rem_x;
    logic [COORD_BITS-1:0] rem_y;
  } segx_div_t;

endpackage

FILE: hw/rtl/segment_intersection.sv
// Top level of the segment intersection block: joins the setup stages and the
// divider and handles the stall. Depends on segx_pkg, segx_front and segx_div.
`timescale 1ns / 1ps
// Takes one segment pair per cycle unless stalled and returns one result per
// pair, in order; the 36-stage divider is an input register followed by 35
// stages that each yield one quotient bit. A stall at the output holds the
// whole pipeline in place, but in_stall is raised only while a valid result
// is held.
module segment_intersection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  segx_pkg::segx_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output segx_pkg::segx_out_t out_data
);
  import segx_pkg::*;

  logic                adv;
  logic                f_v, d_v;
  segx_div_t           f_d;
  logic [MAG_BITS-1:0] f_nx, f_ny;
  segx_out_t           d_d;

  assign adv       = !(d_v && out_stall);
  assign in_stall  = !adv;
  assign out_valid = d_v;
  assign out_data  = d_d;

  segx_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_valid), .in_d(in_data),
    .out_v(f_v), .out_d(f_d), .out_nx(f_nx), .out_ny(f_ny)
  );

  segx_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(f_v), .in_d(f_d),
    .in_nx(f_nx), .in_ny(f_ny), .out_v(d_v), .out_d(d_d)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no result held");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.cross_x == '0 && out_data.cross_y == '0))
    else $error("point nonzero on a miss");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

FILE: hw/rtl/segx_front.sv
// Front stages of the segment intersection pipeline: differences, cross products,
// parameter range tests and the offset numerators. Depends on segx_pkg.
`timescale 1ns / 1ps
module segx_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  segx_pkg::segx_in_t   in_d,
  output logic                 out_v,
  output segx_pkg::segx_div_t  out_d,
  output logic [segx_pkg::MAG_BITS-1:0] out_nx,
  output logic [segx_pkg::MAG_BITS-1:0] out_ny
);
  import segx_pkg::*;

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [DEN_BITS-1:0]  wide_t;
  // Point numerator: start*den + rnum*delta, bounded by 2^16 * 2^35.
  localparam int NUM_BITS = COORD_BITS + DEN_BITS + 2;
  typedef logic signed [NUM_BITS-1:0] num_t;

  // Stage 1: differences.
  logic  v1_r;
  diff_t ox_r, oy_r, ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_BITS-1:0] x0_r, y0_r;

  // Stage 2: products.
  logic  v2_r;
  logic signed [PROD_BITS-1:0] p_axby_r, p_aybx_r, p_oybx_r, p_oxby_r, p_oyax_r, p_oxay_r;
  diff_t ax2_r, ay2_r;
  logic signed [COORD_BITS-1:0] x02_r, y02_r;

  // Stage 3: den and numerators.
  logic  v3_r;
  wide_t den_r, rnum_r, snum_r;
  diff_t ax3_r, ay3_r;
  logic signed [COORD_BITS-1:0] x03_r, y03_r;

  // Stage 4: range test and point products.
  logic  v4_r, hit4_r;
  wide_t den4_r;
  num_t  sx_r, sy_r, rx_r, ry_r;

  // Stage 5: point numerators and magnitudes.
  logic  v5_r;
  segx_div_t d5_r;
  logic [MAG_BITS-1:0] nx5_r, ny5_r;

  wide_t rn_adj, sn_adj, dn_adj, den_mag;
  num_t  nx, ny, nx_mag, ny_mag;
  logic  in_r, in_s;

  always_comb begin
    dn_adj = den_r[DEN_BITS-1] ? -den_r : den_r;
    rn_adj = den_r[DEN_BITS-1] ? -rnum_r : rnum_r;
    sn_adj = den_r[DEN_BITS-1] ? -snum_r : snum_r;
    in_r = !rn_adj[DEN_BITS-1] && (rn_adj <= dn_adj);
    in_s = !sn_adj[DEN_BITS-1] && (sn_adj <= dn_adj);
    nx = sx_r + rx_r;
    ny = sy_r + ry_r;
    nx_mag = nx[NUM_BITS-1] ? -nx : nx;
    ny_mag = ny[NUM_BITS-1] ? -ny : ny;
    den_mag = den4_r[DEN_BITS-1] ? -den4_r : den4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= diff_t'(in_d.a_start_x) - diff_t'(in_d.b_start_x);
      oy_r <= diff_t'(in_d.a_start_y) - diff_t'(in_d.b_start_y);
      ax_r <= diff_t'(in_d.a_end_x) - diff_t'(in_d.a_start_x);
      ay_r <= diff_t'(in_d.a_end_y) - diff_t'(in_d.a_start_y);
      bx_r <= diff_t'(in_d.b_end_x) - diff_t'(in_d.b_start_x);
      by_r <= diff_t'(in_d.b_end_y) - diff_t'(in_d.b_start_y);
      x0_r <= in_d.a_start_x;
      y0_r <= in_d.a_start_y;

      p_axby_r <= prod_t'(ax_r) * prod_t'(by_r);
      p_aybx_r <= prod_t'(ay_r) * prod_t'(bx_r);
      p_oybx_r <= prod_t'(oy_r) * prod_t'(bx_r);
      p_oxby_r <= prod_t'(ox_r) * prod_t'(by_r);
      p_oyax_r <= prod_t'(oy_r) * prod_t'(ax_r);
      p_oxay_r <= prod_t'(ox_r) * prod_t'(ay_r);
      ax2_r <= ax_r;
      ay2_r <= ay_r;
      x02_r <= x0_r;
      y02_r <= y0_r;

      den_r  <= wide_t'(p_axby_r) - wide_t'(p_aybx_r);
      rnum_r <= wide_t'(p_oybx_r) - wide_t'(p_oxby_r);
      snum_r <= wide_t'(p_oyax_r) - wide_t'(p_oxay_r);
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      x03_r <= x02_r;
      y03_r <= y02_r;

      hit4_r <= (den_r != '0) && in_r && in_s;
      den4_r <= den_r;
      sx_r <= num_t'(x03_r) * num_t'(den_r);
      sy_r <= num_t'(y03_r) * num_t'(den_r);
      rx_r <= num_t'(rnum_r) * num_t'(ax3_r);
      ry_r <= num_t'(rnum_r) * num_t'(ay3_r);

      d5_r.hit <= hit4_r;
      d5_r.neg_x <= nx[NUM_BITS-1] ^ den4_r[DEN_BITS-1];
      d5_r.neg_y <= ny[NUM_BITS-1] ^ den4_r[DEN_BITS-1];
      d5_r.den_mag <= den_mag;
      // On a hit the quotient magnitude fits in COORD_BITS, so the numerator
      // magnitude stays below den * 2^COORD_BITS and MAG_BITS + COORD_BITS bits.
      nx5_r <= nx_mag[MAG_BITS-1:0];
      ny5_r <= ny_mag[MAG_BITS-1:0];
      {d5_r.rem_x} <= nx_mag[MAG_BITS+COORD_BITS-1:MAG_BITS];
      {d5_r.rem_y} <= ny_mag[MAG_BITS+COORD_BITS-1:MAG_BITS];
    end
  end

  assign out_v  = v5_r;
  assign out_d  = d5_r;
  assign out_nx = nx5_r;
  assign out_ny = ny5_r;

endmodule

FILE: hw/rtl/segx_div.sv
// Pipelined restoring divider for the two point coordinates, one quotient bit
// per stage. Depends on segx_pkg.
`timescale 1ns / 1ps
module segx_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  segx_pkg::segx_div_t           in_d,
  input  logic [segx_pkg::MAG_BITS-1:0] in_nx,
  input  logic [segx_pkg::MAG_BITS-1:0] in_ny,
  output logic                          out_v,
  output segx_pkg::segx_out_t           out_d
);
  import segx_pkg::*;

  localparam int N = MAG_BITS;
  // Partial remainder is below 2*den, one bit wider than den.
  typedef logic [N:0] rem_t;

  logic                v_r  [0:N];
  segx_div_t           d_r  [0:N];
  rem_t                rx_r [0:N];
  rem_t                ry_r [0:N];
  logic [N-1:0]        nx_r [0:N];
  logic [N-1:0]        ny_r [0:N];

  segx_out_t res;
  logic [N-1:0] qx, qy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int i = 1; i <= N; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    rem_t tx, ty;
    if (adv) begin
      d_r[0]  <= in_d;
      rx_r[0] <= rem_t'(in_d.rem_x);
      ry_r[0] <= rem_t'(in_d.rem_y);
      nx_r[0] <= in_nx;
      ny_r[0] <= in_ny;
      for (int i = 1; i <= N; i++) begin
        tx = {rx_r[i-1][N-1:0], nx_r[i-1][N-1]};
        ty = {ry_r[i-1][N-1:0], ny_r[i-1][N-1]};
        d_r[i] <= d_r[i-1];
        if (tx >= rem_t'(d_r[i-1].den_mag)) begin
          rx_r[i] <= tx - rem_t'(d_r[i-1].den_mag);
          nx_r[i] <= {nx_r[i-1][N-2:0], 1'b1};
        end else begin
          rx_r[i] <= tx;
          nx_r[i] <= {nx_r[i-1][N-2:0], 1'b0};
        end
        if (ty >= rem_t'(d_r[i-1].den_mag)) begin
          ry_r[i] <= ty - rem_t'(d_r[i-1].den_mag);
          ny_r[i] <= {ny_r[i-1][N-2:0], 1'b1};
        end else begin
          ry_r[i] <= ty;
          ny_r[i] <= {ny_r[i-1][N-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    qx = d_r[N].neg_x ? -nx_r[N] : nx_r[N];
    qy = d_r[N].neg_y ? -ny_r[N] : ny_r[N];
    res.hit = d_r[N].hit;
    res.cross_x = d_r[N].hit ? qx[COORD_BITS-1:0] : '0;
    res.cross_y = d_r[N].hit ? qy[COORD_BITS-1:0] : '0;
  end

  assign out_v = v_r[N];
  assign out_d = res;

endmodule
